@@ sv/rir_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the RGB image resampler.
// No dependencies; every other file of the block imports this package.
package rir_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Fixed field widths
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned STEP_W    = 24;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIX_W     = 3 * CHAN_W;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = COORD_W + STEP_W;
  localparam int unsigned NBR_CNT   = 4;
  localparam int unsigned CHAN_CNT  = 3;

  // Parameter defaults
  localparam int unsigned DEF_MAX_WIDTH   = 256;
  localparam int unsigned DEF_MAX_HEIGHT  = 256;
  localparam int unsigned DEF_WEIGHT_BITS = 8;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_SRC_SIZE = 9'd256;
  localparam logic [STEP_W-1:0] RST_STEP     = 24'h01_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_H_STEP     = 3'd3,
    REG_V_STEP     = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [SIZE_W-1:0]  src_width;
    logic [SIZE_W-1:0]  src_height;
    logic [STEP_W-1:0]  h_step;
    logic [STEP_W-1:0]  v_step;
  } cfg_t;

  // Control of one item handed from the address stages to the fetch stage
  typedef struct packed {
    logic valid;
    logic sample;
    logic bilinear;
  } item_ctl_t;

endpackage

@@ sv/rir_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the resampler: input items and result pixels.
// Depends on rir_pkg for the field widths.
interface rir_in_if;
  import rir_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  in_red;
  logic [CHAN_W-1:0]  in_green;
  logic [CHAN_W-1:0]  in_blue;

  modport source (
    output valid, operation, column, row, in_red, in_green, in_blue,
    input  ready
  );
  modport sink (
    input  valid, operation, column, row, in_red, in_green, in_blue,
    output ready
  );
endinterface

interface rir_out_if;
  import rir_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

@@ sv/rir_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the resampler (mode, source size, steps).
// Depends on rir_pkg.
module rir_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rir_pkg::cfg_t                  cfg_o
);
  import rir_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:       cfg_d.mode       = mode_e'(cfg_data_i[0]);
        REG_SRC_WIDTH:  cfg_d.src_width  = cfg_data_i[SIZE_W-1:0];
        REG_SRC_HEIGHT: cfg_d.src_height = cfg_data_i[SIZE_W-1:0];
        REG_H_STEP:     cfg_d.h_step     = cfg_data_i[STEP_W-1:0];
        REG_V_STEP:     cfg_d.v_step     = cfg_data_i[STEP_W-1:0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode:       MODE_BILINEAR,
                 src_width:  RST_SRC_SIZE,
                 src_height: RST_SRC_SIZE,
                 h_step:     RST_STEP,
                 v_step:     RST_STEP};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rir_addr_map.sv @@
`timescale 1ns / 1ps
// Three-stage front end: position multiply, clamp and fractions, store addresses and weights.
// Depends on rir_pkg and rir_in_if.
module rir_addr_map #(
  parameter int unsigned MAX_WIDTH   = rir_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = rir_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned WEIGHT_BITS = rir_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int unsigned WT_W        = 2 * WEIGHT_BITS + 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rir_pkg::cfg_t                           cfg_i,
  rir_in_if.sink                                  item_i,
  output rir_pkg::item_ctl_t                      c_ctl_o,
  output logic [rir_pkg::NBR_CNT-1:0][ADDR_W-1:0] c_addr_o,
  output logic [rir_pkg::NBR_CNT-1:0][WT_W-1:0]   c_wt_o,
  output logic [rir_pkg::PIX_W-1:0]               c_wdata_o,
  input  logic                                    c_take_i
);
  import rir_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned CMP_W = POS_W - FRAC_BITS;
  localparam logic [WEIGHT_BITS:0] WT_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

  // Stage A: scaled source position
  logic               a_valid_q;
  op_e                a_op_q;
  logic [POS_W-1:0]   a_px_q, a_py_q;
  logic [COORD_W-1:0] a_col_q, a_row_q;
  logic [PIX_W-1:0]   a_rgb_q;

  // Stage B: clamped neighbours and fractions
  logic                   b_valid_q;
  logic                   b_sample_q, b_bil_q;
  logic [COL_W-1:0]       b_m_q, b_m1_q;
  logic [ROW_W-1:0]       b_n_q, b_n1_q;
  logic [WEIGHT_BITS-1:0] b_a_q, b_b_q;
  logic [PIX_W-1:0]       b_rgb_q;

  // Stage C: store addresses and blend weights
  logic                           c_valid_q;
  logic                           c_sample_q, c_bil_q;
  logic [NBR_CNT-1:0][ADDR_W-1:0] c_addr_q;
  logic [NBR_CNT-1:0][WT_W-1:0]   c_wt_q;
  logic [PIX_W-1:0]               c_rgb_q;

  logic en_a, en_b, en_c;

  // Effective source size
  logic [CMP_W-1:0] sw, sh, w_eff, h_eff;
  // Stage B combinational
  logic [CMP_W-1:0]       m_full, n_full, m_cl, n_cl, m1, n1, m_sel, n_sel;
  logic [WEIGHT_BITS-1:0] frac_a, frac_b;
  logic                   load_ok, bil;
  // Stage C combinational
  logic [WEIGHT_BITS:0]   ia, ib;

  // Stall chain
  assign en_c = !c_valid_q || c_take_i;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;
  assign item_i.ready = en_a;

  // Size saturation to 1 .. MAX
  assign sw    = CMP_W'(cfg_i.src_width);
  assign sh    = CMP_W'(cfg_i.src_height);
  assign w_eff = (sw == '0) ? CMP_W'(1) :
                 ((sw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : sw);
  assign h_eff = (sh == '0) ? CMP_W'(1) :
                 ((sh > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : sh);

  // Stage B: clamp integer position and right/lower neighbour to the edge
  always_comb begin
    m_full  = a_px_q[POS_W-1:FRAC_BITS];
    n_full  = a_py_q[POS_W-1:FRAC_BITS];
    m_cl    = (m_full >= w_eff) ? w_eff - CMP_W'(1) : m_full;
    n_cl    = (n_full >= h_eff) ? h_eff - CMP_W'(1) : n_full;
    m1      = (m_cl + CMP_W'(1) < w_eff) ? m_cl + CMP_W'(1) : w_eff - CMP_W'(1);
    n1      = (n_cl + CMP_W'(1) < h_eff) ? n_cl + CMP_W'(1) : h_eff - CMP_W'(1);
    load_ok = (CMP_W'(a_col_q) < w_eff) && (CMP_W'(a_row_q) < h_eff);
    bil     = (a_op_q == OP_SAMPLE) && (cfg_i.mode == MODE_BILINEAR);
    // loads carry their own position through the neighbour fields
    m_sel   = (a_op_q == OP_SAMPLE) ? m_cl : CMP_W'(a_col_q);
    n_sel   = (a_op_q == OP_SAMPLE) ? n_cl : CMP_W'(a_row_q);
    // nearest mode: zero fractions put all weight on the base pixel
    frac_b  = bil ? a_px_q[FRAC_BITS-1 -: WEIGHT_BITS] : '0;
    frac_a  = bil ? a_py_q[FRAC_BITS-1 -: WEIGHT_BITS] : '0;
  end

  // Stage C: complementary weights
  assign ia = WT_ONE - {1'b0, b_a_q};
  assign ib = WT_ONE - {1'b0, b_b_q};

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= item_i.valid;
      end
      if (en_b) begin
        // out-of-image loads are dropped here
        b_valid_q <= a_valid_q && ((a_op_q == OP_SAMPLE) || load_ok);
      end
      if (en_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_op_q  <= op_e'(item_i.operation);
      a_px_q  <= POS_W'(item_i.column) * POS_W'(cfg_i.h_step);
      a_py_q  <= POS_W'(item_i.row) * POS_W'(cfg_i.v_step);
      a_col_q <= item_i.column;
      a_row_q <= item_i.row;
      a_rgb_q <= {item_i.in_red, item_i.in_green, item_i.in_blue};
    end
    if (en_b) begin
      b_sample_q <= (a_op_q == OP_SAMPLE);
      b_bil_q    <= bil;
      b_m_q      <= COL_W'(m_sel);
      b_n_q      <= ROW_W'(n_sel);
      b_m1_q     <= COL_W'(m1);
      b_n1_q     <= ROW_W'(n1);
      b_a_q      <= frac_a;
      b_b_q      <= frac_b;
      b_rgb_q    <= a_rgb_q;
    end
    if (en_c) begin
      c_sample_q  <= b_sample_q;
      c_bil_q     <= b_bil_q;
      c_rgb_q     <= b_rgb_q;
      c_addr_q[0] <= ADDR_W'(b_n_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(b_m_q);
      c_addr_q[1] <= ADDR_W'(b_n_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(b_m1_q);
      c_addr_q[2] <= ADDR_W'(b_n1_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(b_m_q);
      c_addr_q[3] <= ADDR_W'(b_n1_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(b_m1_q);
      c_wt_q[0]   <= WT_W'(ia) * WT_W'(ib);
      c_wt_q[1]   <= WT_W'(ia) * WT_W'(b_b_q);
      c_wt_q[2]   <= WT_W'(b_a_q) * WT_W'(ib);
      c_wt_q[3]   <= WT_W'(b_a_q) * WT_W'(b_b_q);
    end
  end

  assign c_ctl_o   = '{valid: c_valid_q, sample: c_sample_q, bilinear: c_bil_q};
  assign c_addr_o  = c_addr_q;
  assign c_wt_o    = c_wt_q;
  assign c_wdata_o = c_rgb_q;

endmodule

@@ sv/rir_fetch.sv @@
`timescale 1ns / 1ps
// Frame store and neighbour fetch sequencer on its single read/write port.
// Depends on rir_pkg.
module rir_fetch #(
  parameter int unsigned MAX_WIDTH   = rir_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = rir_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned WEIGHT_BITS = rir_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int unsigned WT_W        = 2 * WEIGHT_BITS + 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rir_pkg::item_ctl_t                      c_ctl_i,
  input  logic [rir_pkg::NBR_CNT-1:0][ADDR_W-1:0] c_addr_i,
  input  logic [rir_pkg::NBR_CNT-1:0][WT_W-1:0]   c_wt_i,
  input  logic [rir_pkg::PIX_W-1:0]               c_wdata_i,
  output logic                                    c_take_o,
  output logic                                    d_valid_o,
  output logic [rir_pkg::NBR_CNT-1:0][rir_pkg::PIX_W-1:0] d_pix_o,
  output logic [rir_pkg::NBR_CNT-1:0][WT_W-1:0]   d_wt_o,
  input  logic                                    e_ready_i
);
  import rir_pkg::*;

  localparam int unsigned DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned NBR_W    = $clog2(NBR_CNT);
  localparam int unsigned RD_CNT_W = NBR_W + 1;
  localparam logic [RD_CNT_W-1:0] READS_BILINEAR = RD_CNT_W'(NBR_CNT);
  localparam logic [RD_CNT_W-1:0] READS_NEAREST  = RD_CNT_W'(1);

  logic [PIX_W-1:0] frame_store_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Fetch stage state
  logic                           d_valid_q, d_bil_q;
  logic [RD_CNT_W-1:0]            d_issued_q;
  logic [NBR_CNT-1:0][ADDR_W-1:0] d_addr_q;
  logic [NBR_CNT-1:0][WT_W-1:0]   d_wt_q;
  logic [NBR_CNT-1:0][PIX_W-1:0]  d_pix_q;
  logic                           rd_pend_q;
  logic [NBR_W-1:0]               rd_idx_q;

  logic [RD_CNT_W-1:0] need;
  logic                d_issue, d_done, d_free;
  logic                take_sample, take_load;
  logic                mem_re, mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [NBR_W-1:0]    rd_idx_d;

  // Port arbitration: the stage's own reads first, then a new item's first
  // read or a load's write
  always_comb begin
    need        = d_bil_q ? READS_BILINEAR : READS_NEAREST;
    d_issue     = d_valid_q && (d_issued_q != need);
    d_done      = d_valid_q && !d_issue;
    d_free      = !d_valid_q || (d_done && e_ready_i);
    take_sample = c_ctl_i.valid && c_ctl_i.sample && d_free;
    take_load   = c_ctl_i.valid && !c_ctl_i.sample && !d_issue;
    mem_re      = d_issue || take_sample;
    mem_we      = take_load;
    mem_addr    = d_issue ? d_addr_q[d_issued_q[NBR_W-1:0]] : c_addr_i[0];
    rd_idx_d    = d_issue ? d_issued_q[NBR_W-1:0] : '0;
  end

  assign c_take_o = take_sample || take_load;

  // Frame store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store_q[mem_addr] <= c_wdata_i;
    end
    if (mem_re) begin
      rdata_q <= frame_store_q[mem_addr];
    end
  end

  // Last read's data forwarded straight from the store output; nearest mode
  // fills every neighbour with the single read
  always_comb begin
    for (int i = 0; i < NBR_CNT; i++) begin
      d_pix_o[i] = (rd_pend_q && (!d_bil_q || (rd_idx_q == NBR_W'(i)))) ?
                   rdata_q : d_pix_q[i];
    end
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q  <= 1'b0;
      d_issued_q <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      rd_pend_q <= mem_re;
      if (take_sample) begin
        d_valid_q  <= 1'b1;
        d_issued_q <= READS_NEAREST;
      end else if (d_done && e_ready_i) begin
        d_valid_q  <= 1'b0;
      end else if (d_issue) begin
        d_issued_q <= d_issued_q + RD_CNT_W'(1);
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    d_pix_q  <= d_pix_o;
    if (take_sample) begin
      d_bil_q  <= c_ctl_i.bilinear;
      d_addr_q <= c_addr_i;
      d_wt_q   <= c_wt_i;
    end
  end

  assign d_valid_o = d_done;
  assign d_wt_o    = d_wt_q;

endmodule

@@ sv/rir_blend.sv @@
`timescale 1ns / 1ps
// Two-stage weighted blend of four neighbours and the result output register.
// Depends on rir_pkg and rir_out_if.
module rir_blend #(
  parameter int unsigned WEIGHT_BITS = rir_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned WT_W        = 2 * WEIGHT_BITS + 1
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            d_valid_i,
  input  logic [rir_pkg::NBR_CNT-1:0][rir_pkg::PIX_W-1:0] d_pix_i,
  input  logic [rir_pkg::NBR_CNT-1:0][WT_W-1:0]           d_wt_i,
  output logic                                            ready_o,
  rir_out_if.source                                       result_o
);
  import rir_pkg::*;

  localparam int unsigned PROD_W = WT_W + CHAN_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic                                          e_valid_q, f_valid_q;
  logic [CHAN_CNT-1:0][NBR_CNT-1:0][PROD_W-1:0]  e_prod_q, e_prod_d;
  logic [CHAN_CNT-1:0][CHAN_W-1:0]               f_rgb_q, f_rgb_d;
  logic [SUM_W-1:0]                              sum;
  logic                                          en_e, en_f;

  assign en_f    = !f_valid_q || result_o.ready;
  assign en_e    = !e_valid_q || en_f;
  assign ready_o = en_e;

  // Weight times component, channel 0 is blue
  always_comb begin
    for (int c = 0; c < CHAN_CNT; c++) begin
      for (int i = 0; i < NBR_CNT; i++) begin
        e_prod_d[c][i] = PROD_W'(d_wt_i[i]) * PROD_W'(d_pix_i[i][c*CHAN_W +: CHAN_W]);
      end
    end
  end

  // Sum of the four products, truncated back to the component width
  always_comb begin
    sum = '0;
    for (int c = 0; c < CHAN_CNT; c++) begin
      sum = SUM_W'(e_prod_q[c][0]) + SUM_W'(e_prod_q[c][1])
          + SUM_W'(e_prod_q[c][2]) + SUM_W'(e_prod_q[c][3]);
      f_rgb_d[c] = sum[2*WEIGHT_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (en_e) begin
        e_valid_q <= d_valid_i;
      end
      if (en_f) begin
        f_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      e_prod_q <= e_prod_d;
    end
    if (en_f) begin
      f_rgb_q <= f_rgb_d;
    end
  end

  assign result_o.valid     = f_valid_q;
  assign result_o.out_red   = f_rgb_q[2];
  assign result_o.out_green = f_rgb_q[1];
  assign result_o.out_blue  = f_rgb_q[0];

endmodule

@@ sv/rgb_image_resampler_top.sv @@
`timescale 1ns / 1ps
// Top level of the RGB image resampler: config registers, address front end,
// frame store fetch and blend. Depends on rir_pkg, rir_if and all rir_* modules.
//
//  Channel   Dir  Handshake               Carries
//  item_i    in   valid/ready, transfer   operation, column, row, in_red/green/blue
//  result_o  out  valid/ready, transfer   out_red, out_green, out_blue
//  cfg       in   cfg_we_i, no wait       cfg_idx_i, cfg_data_i
//
// A bilinear sample holds the frame store port for one read per neighbour; a
// nearest sample makes a single read and a load a single write. The
// single-port frame store sets the rate. Reset clears valid bits and sets
// config to its reset values; the store is not cleared. Stalls on result_o
// back up stage by stage.
module rgb_image_resampler_top #(
  parameter int unsigned MAX_WIDTH   = rir_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = rir_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned WEIGHT_BITS = rir_pkg::DEF_WEIGHT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rir_in_if.sink                         item_i,
  rir_out_if.source                      result_o
);
  import rir_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned WT_W   = 2 * WEIGHT_BITS + 1;

  cfg_t                           cfg;
  item_ctl_t                      c_ctl;
  logic [NBR_CNT-1:0][ADDR_W-1:0] c_addr;
  logic [NBR_CNT-1:0][WT_W-1:0]   c_wt;
  logic [PIX_W-1:0]               c_wdata;
  logic                           c_take;
  logic                           d_valid;
  logic [NBR_CNT-1:0][PIX_W-1:0]  d_pix;
  logic [NBR_CNT-1:0][WT_W-1:0]   d_wt;
  logic                           e_ready;

  rir_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rir_addr_map #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .ADDR_W      (ADDR_W),
    .WT_W        (WT_W)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_i),
    .c_ctl_o   (c_ctl),
    .c_addr_o  (c_addr),
    .c_wt_o    (c_wt),
    .c_wdata_o (c_wdata),
    .c_take_i  (c_take)
  );

  rir_fetch #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .ADDR_W      (ADDR_W),
    .WT_W        (WT_W)
  ) u_fetch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .c_ctl_i   (c_ctl),
    .c_addr_i  (c_addr),
    .c_wt_i    (c_wt),
    .c_wdata_i (c_wdata),
    .c_take_o  (c_take),
    .d_valid_o (d_valid),
    .d_pix_o   (d_pix),
    .d_wt_o    (d_wt),
    .e_ready_i (e_ready)
  );

  rir_blend #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .WT_W        (WT_W)
  ) u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .d_valid_i (d_valid),
    .d_pix_i   (d_pix),
    .d_wt_i    (d_wt),
    .ready_o   (e_ready),
    .result_o  (result_o)
  );

endmodule
